[src/msp_pkg.sv]
// Shared types and constants for the magnetic strip position tracker.
// Used by every module under src; depends on nothing else.
`default_nettype none

package msp_pkg;

  localparam int NUM_CELLS = 8;
  localparam int QUO_BITS  = 9;  // |position| stays below 512

  typedef logic signed [7:0] sample_t;
  typedef logic signed [9:0] pos_t;

  typedef struct packed {
    logic    op;
    sample_t sensor_0;
    sample_t sensor_1;
    sample_t sensor_2;
    sample_t sensor_3;
    sample_t sensor_4;
    sample_t sensor_5;
    sample_t sensor_6;
    sample_t sensor_7;
  } in_item_t;

  typedef struct packed {
    pos_t position;
    logic online;
  } out_item_t;

  // Peak found by the merge stage and its two neighbors
  typedef struct packed {
    logic [2:0] idx;
    sample_t    best;
    sample_t    a;
    sample_t    b;
    sample_t    c;
  } peak_t;

  typedef enum logic [1:0] {
    CFG_WEAK       = 2'd0,
    CFG_EDGE       = 2'd1,
    CFG_LOST_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_MERGE,
    ST_CALC,
    ST_FINISH
  } st_t;

  localparam sample_t    WEAK_RST       = 8'sd15;
  localparam logic [6:0] LOST_LIMIT_RST = 7'd10;
  localparam logic [6:0] COUNT_MAX      = 7'd127;
  localparam pos_t       LOST_POS       = 10'sd320;
  localparam pos_t       EDGE_POS       = 10'sd300;

  // Cell center in hundredths: 350 - 100 * idx
  function automatic pos_t base_of(input logic [2:0] idx);
    pos_t b;
    case (idx)
      3'd0:    b = 10'sd350;
      3'd1:    b = 10'sd250;
      3'd2:    b = 10'sd150;
      3'd3:    b = 10'sd50;
      3'd4:    b = -10'sd50;
      3'd5:    b = -10'sd150;
      3'd6:    b = -10'sd250;
      default: b = -10'sd350;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[src/msp_lane.sv]
// One sensor lane: negates a raw reading (-128 wraps to itself) and holds it.
// Depends on msp_pkg.
`default_nettype none

module msp_lane (
  input  wire              clk,
  input  wire              load,
  input  msp_pkg::sample_t raw,
  output msp_pkg::sample_t neg_r
);

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= -raw;
    end
  end

endmodule

`default_nettype wire

[src/msp_merge.sv]
// Merge stage: first maximum over the lane values plus neighbor pick.
// Depends on msp_pkg.
`default_nettype none

module msp_merge (
  input  wire              clk,
  input  wire              load,
  input  msp_pkg::sample_t vals [msp_pkg::NUM_CELLS],
  output msp_pkg::peak_t   peak_r
);

  msp_pkg::sample_t l1_val [4];
  logic [2:0]       l1_idx [4];
  msp_pkg::sample_t l2_val [2];
  logic [2:0]       l2_idx [2];
  msp_pkg::sample_t top_val;
  logic [2:0]       top_idx;
  msp_pkg::peak_t   peak_nxt;

  // Ties keep the left (lower) index, so the first maximum wins
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (vals[2*j+1] > vals[2*j]) begin
        l1_val[j] = vals[2*j+1];
        l1_idx[j] = 3'(2*j+1);
      end else begin
        l1_val[j] = vals[2*j];
        l1_idx[j] = 3'(2*j);
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (l1_val[2*j+1] > l1_val[2*j]) begin
        l2_val[j] = l1_val[2*j+1];
        l2_idx[j] = l1_idx[2*j+1];
      end else begin
        l2_val[j] = l1_val[2*j];
        l2_idx[j] = l1_idx[2*j];
      end
    end
    if (l2_val[1] > l2_val[0]) begin
      top_val = l2_val[1];
      top_idx = l2_idx[1];
    end else begin
      top_val = l2_val[0];
      top_idx = l2_idx[0];
    end
  end

  always_comb begin
    peak_nxt.idx  = top_idx;
    peak_nxt.best = top_val;
    peak_nxt.a    = '0;
    peak_nxt.b    = '0;
    peak_nxt.c    = '0;
    // edge cells have no interpolation window
    for (int k = 1; k < msp_pkg::NUM_CELLS - 1; k++) begin
      if (top_idx == 3'(k)) begin
        peak_nxt.a = vals[k-1];
        peak_nxt.b = vals[k];
        peak_nxt.c = vals[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      peak_r <= peak_nxt;
    end
  end

endmodule

`default_nettype wire

[src/msp_interp.sv]
// Position from the peak: lost/edge cases, then three-point interpolation
// through a bit-serial restoring divider. Depends on msp_pkg.
`default_nettype none

module msp_interp (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  msp_pkg::peak_t   peak,
  input  msp_pkg::sample_t weak_thr,
  input  wire              prev_neg,
  output logic             done_r,
  output msp_pkg::pos_t    pos_r
);

  localparam int QB = msp_pkg::QUO_BITS;

  // setup stage
  logic signed [8:0]  d;
  msp_pkg::sample_t   mn;
  logic [8:0]         spread;
  logic [8:0]         absd;
  logic [9:0]         den;
  logic signed [15:0] num;
  logic               direct;
  msp_pkg::pos_t      dpos;

  logic               p1_v_r;
  logic               direct_r;
  msp_pkg::pos_t      dpos_r;
  msp_pkg::pos_t      base_r;
  logic [9:0]         den_r;
  logic signed [15:0] num_r;

  // dividend stage
  logic signed [18:0] nval;
  logic [17:0]        mag;

  // divider
  logic [QB-1:0]      rem_r;
  logic [QB-1:0]      rem_nxt;
  logic [QB-1:0]      dq_r;
  logic [QB-1:0]      dq_nxt;
  logic [QB:0]        trial;
  logic               ge;
  logic               neg_r;
  logic [3:0]         cnt_r;
  logic               run_r;
  logic               last_step;
  msp_pkg::pos_t      qs;
  msp_pkg::pos_t      qpos;

  // den = |a-c| + (b - min(a,c)); numerator term is always 100*(a-c)
  always_comb begin
    d      = 9'(peak.a) - 9'(peak.c);
    mn     = (peak.a > peak.c) ? peak.c : peak.a;
    spread = 9'(9'(peak.b) - 9'(mn));
    absd   = d[8] ? 9'(-d) : 9'(d);
    den    = {1'b0, absd} + {1'b0, spread};
    num    = 16'(d) * 16'sd100;

    direct = 1'b1;
    if (peak.best < weak_thr) begin
      dpos = prev_neg ? -msp_pkg::LOST_POS : msp_pkg::LOST_POS;
    end else if (peak.idx == 3'd0) begin
      dpos = msp_pkg::EDGE_POS;
    end else if (peak.idx == 3'(msp_pkg::NUM_CELLS - 1)) begin
      dpos = -msp_pkg::EDGE_POS;
    end else begin
      dpos   = msp_pkg::base_of(peak.idx);
      direct = (den == '0);
    end
  end

  always_comb begin
    nval = 19'(base_r) * 19'($signed({1'b0, den_r})) + 19'(num_r);
    mag  = nval[18] ? 18'(-nval) : 18'(nval);
  end

  always_comb begin
    trial     = {rem_r, dq_r[QB-1]};
    ge        = (trial >= den_r);
    rem_nxt   = ge ? QB'(trial - den_r) : trial[QB-1:0];
    dq_nxt    = {dq_r[QB-2:0], ge};
    last_step = run_r && (cnt_r == 4'd1);
    qs        = msp_pkg::pos_t'({1'b0, dq_nxt});
    qpos      = neg_r ? -qs : qs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      p1_v_r <= start;
      done_r <= (p1_v_r && direct_r) || last_step;
      if (p1_v_r && !direct_r) begin
        run_r <= 1'b1;
        cnt_r <= 4'(QB);
      end else if (run_r) begin
        run_r <= !last_step;
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      direct_r <= direct;
      dpos_r   <= dpos;
      base_r   <= msp_pkg::base_of(peak.idx);
      den_r    <= den;
      num_r    <= num;
    end
    // quotient fits QB bits, so the top of |N| starts as the remainder
    if (p1_v_r && !direct_r) begin
      rem_r <= mag[17:QB];
      dq_r  <= mag[QB-1:0];
      neg_r <= nval[18];
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
    if (p1_v_r && direct_r) begin
      pos_r <= dpos_r;
    end else if (last_step) begin
      pos_r <= qpos;
    end
  end

endmodule

`default_nettype wire

[src/magnetic_strip_position_tracker.sv]
// Magnetic strip position tracker, top level. One item in flight at a time.
// A period without a frame goes straight to the finish state; a frame passes
// the lanes and merge stage, then lost or edge peaks take a direct position,
// others are interpolated in the one-bit-per-cycle divider. Results wait in an
// output register while the next item is taken. Synchronous active-low reset.
`default_nettype none

module magnetic_strip_position_tracker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  msp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output msp_pkg::out_item_t out_data,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_idx,
  input  wire [7:0]          cfg_data
);

  localparam int N = msp_pkg::NUM_CELLS;

  msp_pkg::st_t       state_r, state_nxt;
  logic               in_ready, accept, merge_load, calc_start, finish_fire;

  msp_pkg::sample_t   weak_thr_r;
  logic [6:0]         lost_limit_r;

  msp_pkg::pos_t      last_pos_r;
  logic [6:0]         lost_cnt_r;
  logic               online_r;
  logic               op_r;

  msp_pkg::sample_t   raw [N];
  msp_pkg::sample_t   lane_val [N];
  msp_pkg::peak_t     peak;
  logic               calc_done;
  msp_pkg::pos_t      calc_pos;

  logic [6:0]         lost_cnt_nxt;
  logic               online_nxt;
  msp_pkg::pos_t      pos_nxt;
  logic               out_valid_r;
  msp_pkg::out_item_t out_data_r;

  assign raw[0] = in_data.sensor_0;
  assign raw[1] = in_data.sensor_1;
  assign raw[2] = in_data.sensor_2;
  assign raw[3] = in_data.sensor_3;
  assign raw[4] = in_data.sensor_4;
  assign raw[5] = in_data.sensor_5;
  assign raw[6] = in_data.sensor_6;
  assign raw[7] = in_data.sensor_7;

  for (genvar k = 0; k < N; k++) begin : g_lane
    msp_lane u_lane (
      .clk   (clk),
      .load  (accept),
      .raw   (raw[k]),
      .neg_r (lane_val[k])
    );
  end

  msp_merge u_merge (
    .clk    (clk),
    .load   (merge_load),
    .vals   (lane_val),
    .peak_r (peak)
  );

  msp_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (calc_start),
    .peak     (peak),
    .weak_thr (weak_thr_r),
    .prev_neg (last_pos_r[9]),
    .done_r   (calc_done),
    .pos_r    (calc_pos)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_data.op ? msp_pkg::ST_LANE : msp_pkg::ST_FINISH;
        end
      end
      msp_pkg::ST_LANE:   state_nxt = msp_pkg::ST_MERGE;
      msp_pkg::ST_MERGE:  state_nxt = msp_pkg::ST_CALC;
      msp_pkg::ST_CALC: begin
        if (calc_done) begin
          state_nxt = msp_pkg::ST_FINISH;
        end
      end
      msp_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = msp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    merge_load  = 1'b0;
    calc_start  = 1'b0;
    finish_fire = 1'b0;
    case (state_r)
      msp_pkg::ST_IDLE:   in_ready    = 1'b1;
      msp_pkg::ST_LANE:   merge_load  = 1'b1;
      msp_pkg::ST_MERGE:  calc_start  = 1'b1;
      msp_pkg::ST_CALC:   ;
      msp_pkg::ST_FINISH: finish_fire = !out_valid_r || !out_stall;
      default:            ;
    endcase
  end

  assign in_stall = !in_ready;
  assign accept   = in_valid && in_ready;

  // counter saturates first, then a frame clears it
  always_comb begin
    if (op_r) begin
      lost_cnt_nxt = '0;
      pos_nxt      = calc_pos;
    end else begin
      lost_cnt_nxt = (lost_cnt_r == msp_pkg::COUNT_MAX) ? lost_cnt_r : lost_cnt_r + 7'd1;
      pos_nxt      = last_pos_r;
    end
    online_nxt = (op_r || online_r) && !(lost_cnt_nxt > lost_limit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= msp_pkg::ST_IDLE;
      weak_thr_r   <= msp_pkg::WEAK_RST;
      lost_limit_r <= msp_pkg::LOST_LIMIT_RST;
      last_pos_r   <= '0;
      lost_cnt_r   <= '0;
      online_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish_fire || (out_valid_r && out_stall);
      if (finish_fire) begin
        last_pos_r <= pos_nxt;
        lost_cnt_r <= lost_cnt_nxt;
        online_r   <= online_nxt;
      end
      // edge peaks that are not weak give the fixed edge position, so the
      // edge threshold has no storage
      if (cfg_we) begin
        case (msp_pkg::cfg_idx_t'(cfg_idx))
          msp_pkg::CFG_WEAK:       weak_thr_r   <= cfg_data;
          msp_pkg::CFG_EDGE:       ;
          msp_pkg::CFG_LOST_LIMIT: lost_limit_r <= cfg_data[6:0];
          default:                 ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_data.op;
    end
    if (finish_fire) begin
      out_data_r.position <= pos_nxt;
      out_data_r.online   <= online_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
